FILE: src/gbn_pkg.sv
`timescale 1ns / 1ps
package gbn_pkg;

    localparam int IN_COORD_W     = 12;
    localparam int SCORE_W        = 16;
    localparam int IDX_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_BOXES_DEF  = 64;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IOU_THR   = 2'd1;

    localparam logic [SCORE_W-1:0] SCORE_THR_RST = 16'd39322;
    localparam logic [SCORE_W-1:0] IOU_THR_RST   = 16'd19661;

    typedef struct packed {
        logic [IN_COORD_W-1:0] box_x;
        logic [IN_COORD_W-1:0] box_y;
        logic [IN_COORD_W-1:0] box_w;
        logic [IN_COORD_W-1:0] box_h;
        logic [SCORE_W-1:0]    confidence;
        logic                  last_box;
    } t_in;

    typedef struct packed {
        logic [IDX_W-1:0] kept_index;
        logic             none_kept;
        logic             overflow;
        logic             last_result;
    } t_out;

    typedef enum logic [4:0] {
        S_LOAD,
        S_RK_A,
        S_RK_B,
        S_RK_C,
        S_RK_D,
        S_WK_A,
        S_WK_B,
        S_WK_C,
        S_WK_D,
        S_PR_A,
        S_PR_B,
        S_PR_C,
        S_PR_D,
        S_PR_E,
        S_PR_F,
        S_PR_G,
        S_WK_N,
        S_FIN
    } t_state;

endpackage

FILE: src/greedy_box_nms.sv
`timescale 1ns / 1ps
// a set of n boxes loads at one request a cycle; after the last box a ranking
// pass orders the boxes by score, then the suppression walk tests each kept
// box against the boxes behind it, on the single shared multiplier and the
// one-port box and score memories; each kept result is held until taken
// throughput: one run at a time, no request is taken during ranking or walk
// reset: synchronous active low, clears control state and restores the default thresholds only
module greedy_box_nms #(
    parameter int MAX_BOXES  = gbn_pkg::MAX_BOXES_DEF,
    parameter int COORD_BITS = gbn_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [gbn_pkg::SCORE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  gbn_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output gbn_pkg::t_out                 o_out_data
);
    import gbn_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int AW  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CW  = $clog2(MAX_BOXES + 1);
    localparam int BW  = 4 * C;
    localparam int SW  = C + 2;
    localparam int UW  = 2 * C + 1;
    localparam int MAW = (C > SCORE_W) ? C : SCORE_W;
    localparam int PW  = MAW + UW;

    // storage, one port each, registered read data
    logic [BW-1:0]      box_mem   [MAX_BOXES];
    logic [SCORE_W-1:0] score_mem [MAX_BOXES];
    logic [AW-1:0]      order_mem [MAX_BOXES];

    logic [BW-1:0]      box_q;
    logic [SCORE_W-1:0] score_q;
    logic [AW-1:0]      order_q;

    t_state r_state, n_state;

    logic [SCORE_W-1:0]   r_score_thr, r_iou_thr;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_ovf, n_ovf;
    logic [MAX_BOXES-1:0] r_supp, n_supp;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        r_j, n_j;
    logic [CW-1:0]        r_rank, n_rank;
    logic [SCORE_W-1:0]   r_si, n_si;
    logic [AW-1:0]        r_a, n_a;
    logic [AW-1:0]        r_b, n_b;
    logic [BW-1:0]        r_abox, n_abox;
    logic [BW-1:0]        r_bbox, n_bbox;
    logic [C-1:0]         r_ox, n_ox;
    logic [C-1:0]         r_oy, n_oy;
    logic [2*C-1:0]       r_inter, n_inter;
    logic [2*C-1:0]       r_area_a, n_area_a;
    logic [2*C-1:0]       r_area_b, n_area_b;
    logic [PW-1:0]        r_prod, n_prod;
    logic                 r_have_pend, n_have_pend;
    logic [AW-1:0]        r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out_data, n_out_data;

    // memory control
    logic               box_we, score_we, order_we;
    logic [AW-1:0]      wr_addr, order_waddr;
    logic [AW-1:0]      box_raddr, score_raddr, order_raddr;
    logic [BW-1:0]      box_wdata;

    // shared multiplier
    logic [MAW-1:0] mul_a;
    logic [UW-1:0]  mul_b;
    logic [PW-1:0]  mul_p;

    logic           in_acc, out_free, last_n, kept_now, beats;
    logic [CW-1:0]  rank_nxt, n_last;
    logic [UW-1:0]  uni;
    logic signed [SW-1:0] lo_x, hi_x, d_x, lo_y, hi_y, d_y;

    assign in_acc   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;
    assign n_last   = r_count - CW'(1);
    assign mul_p    = PW'(mul_a) * PW'(mul_b);
    assign uni      = UW'(r_area_a) + UW'(r_area_b) - UW'(r_inter);
    assign beats    = PW'({r_inter, 16'h0000}) > r_prod;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign box_wdata = {C'(i_in_data.box_h), C'(i_in_data.box_w),
                        C'(i_in_data.box_y), C'(i_in_data.box_x)};

    always_ff @(posedge i_clk) begin
        if (box_we) begin
            box_mem[wr_addr] <= box_wdata;
        end
        if (score_we) begin
            score_mem[wr_addr] <= i_in_data.confidence;
        end
        if (order_we) begin
            order_mem[order_waddr] <= r_i[AW-1:0];
        end
        box_q   <= box_mem[box_raddr];
        score_q <= score_mem[score_raddr];
        order_q <= order_mem[order_raddr];
    end

    // rank of box i: how many boxes go ahead of it in the walk
    always_comb begin
        rank_nxt = r_rank;
        if ((score_q > r_si) || ((score_q == r_si) && (r_j < r_i))) begin
            rank_nxt = r_rank + CW'(1);
        end
    end

    assign kept_now = !r_supp[r_a] && !(score_q < r_score_thr);

    // inclusive-pixel overlap of box a and the freshly read box b
    always_comb begin
        logic signed [SW-1:0] ax, aw, bx, bw, ay, ah, by, bh, ea, eb;
        ax = SW'($signed({2'b00, r_abox[C-1:0]}));
        ay = SW'($signed({2'b00, r_abox[2*C-1:C]}));
        aw = SW'($signed({2'b00, r_abox[3*C-1:2*C]}));
        ah = SW'($signed({2'b00, r_abox[4*C-1:3*C]}));
        bx = SW'($signed({2'b00, box_q[C-1:0]}));
        by = SW'($signed({2'b00, box_q[2*C-1:C]}));
        bw = SW'($signed({2'b00, box_q[3*C-1:2*C]}));
        bh = SW'($signed({2'b00, box_q[4*C-1:3*C]}));
        lo_x = (ax > bx) ? ax : bx;
        ea   = ax + aw - SW'(1);
        eb   = bx + bw - SW'(1);
        hi_x = (ea < eb) ? ea : eb;
        d_x  = hi_x - lo_x + SW'(1);
        lo_y = (ay > by) ? ay : by;
        ea   = ay + ah - SW'(1);
        eb   = by + bh - SW'(1);
        hi_y = (ea < eb) ? ea : eb;
        d_y  = hi_y - lo_y + SW'(1);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_LOAD: begin
                if (in_acc && i_in_data.last_box) begin
                    if ((r_count == CW'(0)) && !(r_count < CW'(MAX_BOXES))) begin
                        n_state = S_FIN;
                    end else if (r_count == CW'(0)) begin
                        n_state = S_RK_A;
                    end else begin
                        n_state = S_RK_A;
                    end
                end
            end
            S_RK_A: n_state = S_RK_B;
            S_RK_B: n_state = S_RK_C;
            S_RK_C: n_state = S_RK_D;
            S_RK_D: begin
                if (r_j == n_last) begin
                    n_state = (r_i == n_last) ? S_WK_A : S_RK_A;
                end else begin
                    n_state = S_RK_C;
                end
            end
            S_WK_A: n_state = S_WK_B;
            S_WK_B: n_state = S_WK_C;
            S_WK_C: begin
                if (!kept_now) begin
                    n_state = S_WK_N;
                end else if (!r_have_pend || out_free) begin
                    n_state = S_WK_D;
                end
            end
            S_WK_D: n_state = (r_i == n_last) ? S_WK_N : S_PR_A;
            S_PR_A: n_state = S_PR_B;
            S_PR_B: n_state = S_PR_C;
            S_PR_C: n_state = S_PR_D;
            S_PR_D: n_state = S_PR_E;
            S_PR_E: n_state = S_PR_F;
            S_PR_F: n_state = S_PR_G;
            S_PR_G: n_state = (r_j == n_last) ? S_WK_N : S_PR_A;
            S_WK_N: n_state = (r_i == n_last) ? S_FIN : S_WK_A;
            S_FIN: begin
                if (out_free) begin
                    n_state = S_LOAD;
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_supp      = r_supp;
        n_i         = r_i;
        n_j         = r_j;
        n_rank      = r_rank;
        n_si        = r_si;
        n_a         = r_a;
        n_b         = r_b;
        n_abox      = r_abox;
        n_bbox      = r_bbox;
        n_ox        = r_ox;
        n_oy        = r_oy;
        n_inter     = r_inter;
        n_area_a    = r_area_a;
        n_area_b    = r_area_b;
        n_prod      = r_prod;
        n_have_pend = r_have_pend;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        box_we      = 1'b0;
        score_we    = 1'b0;
        order_we    = 1'b0;
        wr_addr     = r_count[AW-1:0];
        order_waddr = rank_nxt[AW-1:0];
        box_raddr   = order_q;
        score_raddr = r_i[AW-1:0];
        order_raddr = r_i[AW-1:0];
        mul_a       = MAW'(r_ox);
        mul_b       = UW'(r_oy);
        last_n      = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < CW'(MAX_BOXES)) begin
                        box_we   = 1'b1;
                        score_we = 1'b1;
                        n_count  = r_count + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    n_i         = '0;
                    n_have_pend = 1'b0;
                end
            end
            S_RK_A: begin
                score_raddr = r_i[AW-1:0];
            end
            S_RK_B: begin
                n_si   = score_q;
                n_rank = '0;
                n_j    = '0;
            end
            S_RK_C: begin
                score_raddr = r_j[AW-1:0];
            end
            S_RK_D: begin
                n_rank = rank_nxt;
                n_j    = r_j + CW'(1);
                if (r_j == n_last) begin
                    order_we = 1'b1;
                    n_i      = (r_i == n_last) ? '0 : r_i + CW'(1);
                end
            end
            S_WK_A: begin
                order_raddr = r_i[AW-1:0];
            end
            S_WK_B: begin
                n_a         = order_q;
                box_raddr   = order_q;
                score_raddr = order_q;
            end
            S_WK_C: begin
                // keep box a and its score on the read ports while the output stalls
                box_raddr   = r_a;
                score_raddr = r_a;
                if (kept_now && (!r_have_pend || out_free)) begin
                    if (r_have_pend) begin
                        n_out_valid = 1'b1;
                        n_out_data  = '{kept_index: IDX_W'(r_pend), none_kept: 1'b0,
                                        overflow: r_ovf, last_result: 1'b0};
                    end
                    n_have_pend = 1'b1;
                    n_pend      = r_a;
                    n_abox      = box_q;
                end
            end
            S_WK_D: begin
                mul_a    = MAW'(r_abox[3*C-1:2*C]);
                mul_b    = UW'(r_abox[4*C-1:3*C]);
                n_area_a = mul_p[2*C-1:0];
                n_j      = r_i + CW'(1);
            end
            S_PR_A: begin
                order_raddr = r_j[AW-1:0];
            end
            S_PR_B: begin
                n_b       = order_q;
                box_raddr = order_q;
            end
            S_PR_C: begin
                n_bbox = box_q;
                n_ox   = (d_x > SW'(0)) ? d_x[C-1:0] : '0;
                n_oy   = (d_y > SW'(0)) ? d_y[C-1:0] : '0;
            end
            S_PR_D: begin
                mul_a   = MAW'(r_ox);
                mul_b   = UW'(r_oy);
                n_inter = mul_p[2*C-1:0];
            end
            S_PR_E: begin
                mul_a    = MAW'(r_bbox[3*C-1:2*C]);
                mul_b    = UW'(r_bbox[4*C-1:3*C]);
                n_area_b = mul_p[2*C-1:0];
            end
            S_PR_F: begin
                mul_a  = MAW'(r_iou_thr);
                mul_b  = uni;
                n_prod = mul_p;
            end
            S_PR_G: begin
                if (beats) begin
                    n_supp[r_b] = 1'b1;
                end
                n_j = r_j + CW'(1);
            end
            S_WK_N: begin
                n_i = r_i + CW'(1);
            end
            S_FIN: begin
                if (out_free) begin
                    last_n      = 1'b1;
                    n_out_valid = 1'b1;
                    if (r_have_pend) begin
                        n_out_data = '{kept_index: IDX_W'(r_pend), none_kept: 1'b0,
                                       overflow: r_ovf, last_result: 1'b1};
                    end else begin
                        n_out_data = '{kept_index: '0, none_kept: 1'b1,
                                       overflow: r_ovf, last_result: 1'b1};
                    end
                    n_count     = '0;
                    n_ovf       = 1'b0;
                    n_supp      = '0;
                    n_have_pend = 1'b0;
                end
            end
            default: begin
                n_out_valid = r_out_valid && !i_out_ready;
            end
        endcase
        if (last_n) begin
            n_i = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_supp      <= '0;
            r_have_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_score_thr <= SCORE_THR_RST;
            r_iou_thr   <= IOU_THR_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_supp      <= n_supp;
            r_have_pend <= n_have_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && (i_cfg_addr == CFG_SCORE_THR)) begin
                r_score_thr <= i_cfg_data;
            end
            if (i_cfg_we && (i_cfg_addr == CFG_IOU_THR)) begin
                r_iou_thr <= i_cfg_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_j        <= n_j;
        r_rank     <= n_rank;
        r_si       <= n_si;
        r_a        <= n_a;
        r_b        <= n_b;
        r_abox     <= n_abox;
        r_bbox     <= n_bbox;
        r_ox       <= n_ox;
        r_oy       <= n_oy;
        r_inter    <= n_inter;
        r_area_a   <= n_area_a;
        r_area_b   <= n_area_b;
        r_prod     <= n_prod;
        r_pend     <= n_pend;
        r_out_data <= n_out_data;
    end

`ifndef SYNTH
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_BOXES))
        else $error("box count beyond capacity");
    a_busy_has_boxes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD && r_state != S_FIN) |-> (r_count != CW'(0)))
        else $error("walk running on an empty set");
    a_flags_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_supp == '0))
        else $error("suppression flags left over from a run");
    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.none_kept) |-> o_out_data.last_result)
        else $error("empty result not marked last");
`endif

endmodule

FILE: tb/greedy_box_nms_tb.sv
`timescale 1ns / 1ps
module greedy_box_nms_tb;
    import gbn_pkg::*;

    // register indexes above the last real one, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int CAPACITY = MAX_BOXES_DEF;
    localparam int SETTLE   = 60;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [SCORE_W-1:0]   cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in                  in_data = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out                 out_data;

    greedy_box_nms dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // generous watchdog, sized for the largest sets
    initial begin
        #6000000;
        $display("status: fail");
        $finish;
    end

    // predictor state, mirrors the block's stores and thresholds
    logic [IN_COORD_W-1:0] px [CAPACITY], py [CAPACITY], pw [CAPACITY], ph [CAPACITY];
    logic [SCORE_W-1:0]    pscore [CAPACITY];
    int                    pcount = 0;
    bit                    pover = 0;
    logic [SCORE_W-1:0]    score_thr = SCORE_THR_RST;
    logic [SCORE_W-1:0]    iou_thr   = IOU_THR_RST;

    t_out kept_q [$];     // kept boxes still awaited from the block
    t_out walk_q [$];     // scratch output of one prediction
    int   fails = 0;
    int   snd_idle = 32;
    int   rcv_idle = 70;
    int   items = 0;

    typedef struct {
        t_in  req;
        bit   typed;
        t_out want;
    } dir_row_t;

    dir_row_t rows [$];

    // inclusive-pixel overlap along one axis
    function automatic longint span_overlap(longint a, longint la, longint b, longint lb);
        longint lo, hi;
        lo = (a > b) ? a : b;
        hi = ((a + la - 1) < (b + lb - 1)) ? (a + la - 1) : (b + lb - 1);
        return (hi - lo + 1 > 0) ? hi - lo + 1 : 0;
    endfunction

    function automatic bit iou_exceeds(int s, int t);
        longint inter, uni;
        inter = span_overlap(px[s], pw[s], px[t], pw[t])
              * span_overlap(py[s], ph[s], py[t], ph[t]);
        uni = longint'(pw[s]) * ph[s] + longint'(pw[t]) * ph[t] - inter;
        if (uni < 0) uni = 0;
        return inter * 65536 > longint'(iou_thr) * uni;
    endfunction

    // store one box and, on the final box, run the greedy walk into walk_q
    task automatic nms_predict(input t_in r);
        int   order [CAPACITY];
        bit   supp [CAPACITY];
        int   i, j, v, a;
        t_out o;
        walk_q.delete();
        if (pcount < CAPACITY) begin
            px[pcount] = r.box_x; py[pcount] = r.box_y;
            pw[pcount] = r.box_w; ph[pcount] = r.box_h;
            pscore[pcount] = r.confidence;
            pcount++;
        end else begin
            pover = 1;
        end
        if (!r.last_box) return;
        for (i = 0; i < pcount; i++) begin
            v = i;
            j = i;
            while (j > 0 && pscore[order[j-1]] < pscore[v]) begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
            supp[i] = 0;
        end
        for (i = 0; i < pcount; i++) begin
            a = order[i];
            if (supp[a] || pscore[a] < score_thr) continue;
            o = '{kept_index: a[IDX_W-1:0], none_kept: 1'b0, overflow: pover,
                  last_result: 1'b0};
            walk_q = {walk_q, o};
            for (j = i + 1; j < pcount; j++)
                if (!supp[order[j]] && iou_exceeds(a, order[j])) supp[order[j]] = 1;
        end
        if (walk_q.size() == 0) begin
            o = '{kept_index: '0, none_kept: 1'b1, overflow: pover, last_result: 1'b1};
            walk_q = {walk_q, o};
        end else begin
            walk_q[walk_q.size()-1].last_result = 1'b1;
        end
        pcount = 0;
        pover = 0;
    endtask

    // receiver side: random stalls, compare every accepted result
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_valid && out_ready) begin
            if (kept_q.size() == 0) begin
                fails++;
                $display("%0t: result expected none actual %p", $time, out_data);
            end else begin
                want = kept_q.pop_front();
                if (want.kept_index !== out_data.kept_index) begin
                    fails++;
                    $display("%0t: kept_index expected %0d actual %0d", $time,
                             want.kept_index, out_data.kept_index);
                end
                if (want.none_kept !== out_data.none_kept) begin
                    fails++;
                    $display("%0t: none_kept expected %0b actual %0b", $time,
                             want.none_kept, out_data.none_kept);
                end
                if (want.overflow !== out_data.overflow) begin
                    fails++;
                    $display("%0t: overflow expected %0b actual %0b", $time,
                             want.overflow, out_data.overflow);
                end
                if (want.last_result !== out_data.last_result) begin
                    fails++;
                    $display("%0t: last_result expected %0b actual %0b", $time,
                             want.last_result, out_data.last_result);
                end
            end
        end
        out_ready <= ($urandom_range(99) >= rcv_idle);
    end

    // one request; valid stays high across back-to-back requests
    task automatic send_box(input t_in r, input bit typed, input t_out want);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle) gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        do @(posedge i_clk); while (!in_ready);
        nms_predict(r);
        if (typed && r.last_box) kept_q = {kept_q, want};
        else kept_q = {kept_q, walk_q};
        items++;
    endtask

    // hold the sender until the block has handed back every result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SCORE_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SCORE_THR) score_thr = val;
        else if (idx == CFG_IOU_THR) iou_thr = val;
    endtask

    function automatic t_in mk_box(int x, int y, int w, int h, int c, bit l);
        t_in r;
        r.box_x      = IN_COORD_W'(x);
        r.box_y      = IN_COORD_W'(y);
        r.box_w      = IN_COORD_W'(w);
        r.box_h      = IN_COORD_W'(h);
        r.confidence = SCORE_W'(c);
        r.last_box   = l;
        return r;
    endfunction

    function automatic void add_row(input t_in req, input bit typed, input t_out want);
        dir_row_t d;
        d.req   = req;
        d.typed = typed;
        d.want  = want;
        rows    = {rows, d};
    endfunction

    // clustered set so that overlaps and suppression really happen, or random boxes when noise is set
    task automatic run_set(input int n, input bit noise);
        t_in r;
        int  bx, by, spread, c0;
        bx = $urandom_range(4095);
        by = $urandom_range(4095);
        spread = $urandom_range(1, 40);
        c0 = $urandom_range(65535);
        for (int k = 0; k < n; k++) begin
            if (noise) begin
                r = t_in'({$urandom(), $urandom(), 1'b0});
            end else begin
                r.box_x = IN_COORD_W'(bx + $urandom_range(spread));
                r.box_y = IN_COORD_W'(by + $urandom_range(spread));
                r.box_w = IN_COORD_W'($urandom_range(1, 3 * spread));
                r.box_h = IN_COORD_W'($urandom_range(1, 3 * spread));
                // occasional equal scores to exercise the tie rule
                r.confidence = ($urandom_range(3) == 0) ? c0[SCORE_W-1:0]
                                                        : SCORE_W'($urandom());
            end
            r.last_box = (k == n - 1);
            if (r.last_box && $urandom_range(9) == 0) drain();
            send_box(r, 1'b0, '0);
        end
    endtask

    initial begin
        int       n, mode;
        t_out     none0, keep0;
        none0 = '{kept_index: '0, none_kept: 1'b1, overflow: 1'b0, last_result: 1'b1};
        keep0 = '{kept_index: '0, none_kept: 1'b0, overflow: 1'b0, last_result: 1'b1};

        // directed rows under reset thresholds
        add_row(mk_box(0, 0, 0, 0, 0, 1), 1'b1, none0);
        add_row(mk_box(4095, 4095, 4095, 4095, 65535, 1), 1'b1, keep0);
        add_row(mk_box(10, 10, 20, 20, 50000, 0), 1'b0, '0);
        add_row(mk_box(10, 10, 20, 20, 60000, 0), 1'b0, '0);
        add_row(mk_box(12, 12, 20, 20, 60000, 0), 1'b0, '0);
        add_row(mk_box(500, 500, 5, 5, 40000, 1), 1'b0, '0);
        // zero-area boxes neither suppress nor get suppressed
        add_row(mk_box(100, 100, 0, 0, 65535, 0), 1'b0, '0);
        add_row(mk_box(100, 100, 0, 5, 65535, 0), 1'b0, '0);
        add_row(mk_box(100, 100, 5, 0, 65000, 1), 1'b0, '0);
        // score exactly at and just under the threshold
        add_row(mk_box(7, 7, 7, 7, 39322, 1), 1'b1, keep0);
        add_row(mk_box(7, 7, 7, 7, 39321, 1), 1'b1, none0);
        add_row(mk_box(0, 0, 4095, 4095, 65535, 0), 1'b0, '0);
        add_row(mk_box(0, 0, 4095, 4095, 65534, 0), 1'b0, '0);
        add_row(mk_box(4095, 0, 1, 1, 45000, 1), 1'b0, '0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_box(rows[k].req, rows[k].typed, rows[k].want);
        drain();

        // capacity exceeded: 66 boxes, the last two dropped, last one ends the set
        write_reg(CFG_IOU_THR, 16'd0);
        run_set(CAPACITY + 2, 1'b0);
        drain();

        while (items < 270) begin
            if (items > 90 && items <= 180) begin
                snd_idle = 70;
                rcv_idle = 32;
            end else if (items > 180) begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            mode = $urandom_range(5);
            case (mode)
                0: begin
                    write_reg(CFG_SCORE_THR, 16'd0);
                    write_reg(CFG_IOU_THR, 16'hFFFF);
                end
                1: begin
                    write_reg(CFG_SCORE_THR, 16'hFFFF);
                    write_reg(CFG_IOU_THR, 16'd0);
                end
                2: begin
                    write_reg(CFG_SPARE_2, SCORE_W'($urandom()));
                    write_reg(CFG_SPARE_3, SCORE_W'($urandom()));
                    write_reg(CFG_SCORE_THR, SCORE_THR_RST);
                    write_reg(CFG_IOU_THR, IOU_THR_RST);
                end
                default: begin
                    write_reg(CFG_SCORE_THR, SCORE_W'($urandom_range(65535)));
                    write_reg(CFG_IOU_THR, SCORE_W'($urandom_range(65535)));
                end
            endcase
            for (int s = 0; s < 4; s++) begin
                n = ($urandom_range(40) == 0) ? $urandom_range(CAPACITY - 1, CAPACITY + 2)
                                              : $urandom_range(1, 8);
                run_set(n, $urandom_range(4) == 0);
            end
            drain();
        end

        drain();
        if (fails == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
